// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ddalr_pkg.sv =====
// ----------------------------------------------------------------------------
// ddalr_pkg
// Types, constants and the control store of the DDA line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ddalr_pkg;

  // Octant output width.
  localparam int OCT_BITS = 3;

  // Step counter width of the sequencer.
  localparam int STEP_BITS = 3;

  typedef logic [STEP_BITS-1:0] step_t;
  typedef logic [OCT_BITS-1:0]  oct_t;

  // Jump conditions. A true condition loads the target, otherwise the step
  // counter advances by one.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_SKIP_DIV,
    COND_DIV_BUSY,
    COND_PIX_LEFT
  } cond_t;

  // Named program steps.
  localparam step_t STEP_FETCH    = 3'd0;
  localparam step_t STEP_CLASSIFY = 3'd1;
  localparam step_t STEP_PREP     = 3'd2;
  localparam step_t STEP_DIVIDE   = 3'd3;
  localparam step_t STEP_EMIT     = 3'd4;
  localparam step_t STEP_RETURN   = 3'd5;

  // Octant codes, counter-clockwise from shallow positive x.
  localparam oct_t OCT_E_SHALLOW = 3'd0;
  localparam oct_t OCT_E_STEEP   = 3'd1;
  localparam oct_t OCT_W_STEEP   = 3'd2;
  localparam oct_t OCT_W_SHALLOW = 3'd3;
  localparam oct_t OCT_SW_SHALL  = 3'd4;
  localparam oct_t OCT_SW_STEEP  = 3'd5;
  localparam oct_t OCT_SE_STEEP  = 3'd6;
  localparam oct_t OCT_SE_SHALL  = 3'd7;

  // One control word.
  typedef struct packed {
    logic  accept;    // input channel ready, endpoints load on a beat
    logic  classify;  // deltas, octant, major and minor travel
    logic  prep;      // accumulator, position, counters, divider setup
    logic  div_step;  // one quotient bit of the slope
    logic  emit;      // one pixel into the output register
    cond_t cond;
    step_t target;
  } ucode_t;

  // Datapath status seen by the jump logic.
  typedef struct packed {
    logic skip_div;   // equal travels: slope is fixed without dividing
    logic div_busy;   // more quotient bits to come after this step
    logic pix_done;   // the final pixel is loaded this cycle
  } status_t;

  // Control store.
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    w = '{accept: 1'b0, classify: 1'b0, prep: 1'b0, div_step: 1'b0,
          emit: 1'b0, cond: COND_NEVER, target: STEP_FETCH};
    case (s)
      STEP_FETCH: begin
        w.accept = 1'b1;
        w.cond   = COND_NO_INPUT;
        w.target = STEP_FETCH;
      end
      STEP_CLASSIFY: begin
        w.classify = 1'b1;
      end
      STEP_PREP: begin
        w.prep   = 1'b1;
        w.cond   = COND_SKIP_DIV;
        w.target = STEP_EMIT;
      end
      STEP_DIVIDE: begin
        w.div_step = 1'b1;
        w.cond     = COND_DIV_BUSY;
        w.target   = STEP_DIVIDE;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_PIX_LEFT;
        w.target = STEP_EMIT;
      end
      STEP_RETURN: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_FETCH;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ddalr_line_if.sv =====
// ----------------------------------------------------------------------------
// ddalr_line_if / ddalr_pixel_if
// Valid/ready channels for line endpoints in and rasterized pixels out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddalr_line_if #(parameter int COORD_BITS = 6);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface ddalr_pixel_if #(parameter int COORD_BITS = 6);
  logic                           valid;
  logic                           ready;
  logic signed [COORD_BITS-1:0]   pixel_x;
  logic signed [COORD_BITS-1:0]   pixel_y;
  logic [ddalr_pkg::OCT_BITS-1:0] octant;
  logic                           last_pixel;

  modport source (output valid, pixel_x, pixel_y, octant, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, octant, last_pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ddalr_dp.sv =====
// ----------------------------------------------------------------------------
// ddalr_dp
// Rasterizer datapath: octant classifier, bit-serial slope divider,
// fixed-point minor-axis accumulator and the output pixel register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddalr_dp #(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire ddalr_pkg::ucode_t         ctrl,
  output ddalr_pkg::status_t             status,
  input  wire                            in_valid,
  input  wire signed [COORD_BITS-1:0]    start_x,
  input  wire signed [COORD_BITS-1:0]    start_y,
  input  wire signed [COORD_BITS-1:0]    end_x,
  input  wire signed [COORD_BITS-1:0]    end_y,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic signed [COORD_BITS-1:0]   pixel_x,
  output logic signed [COORD_BITS-1:0]   pixel_y,
  output logic [ddalr_pkg::OCT_BITS-1:0] octant,
  output logic                           last_pixel
);

  localparam int AW  = COORD_BITS + FRAC_BITS;
  localparam int DCW = $clog2(FRAC_BITS);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(FRAC_BITS - 1);
  localparam logic [AW-1:0]  HALF     = AW'(1) << (FRAC_BITS - 1);

  // Latched endpoints.
  logic signed [COORD_BITS-1:0] sx, sy, ex, ey;

  // Line set-up.
  logic                  steep;
  logic                  maj_neg;
  logic                  min_neg;
  logic [COORD_BITS-1:0] major;
  logic [COORD_BITS-1:0] minor;
  logic [COORD_BITS-1:0] maj_start;
  logic [COORD_BITS-1:0] min_start;
  ddalr_pkg::oct_t       line_oct;

  // Walk state.
  logic [COORD_BITS-1:0] majpos;
  logic [COORD_BITS-1:0] count;
  logic [AW-1:0]         acc;
  logic [FRAC_BITS-1:0]  slope;
  logic [COORD_BITS-1:0] rem;
  logic [DCW-1:0]        divcnt;

  // Classifier signals.
  logic [COORD_BITS:0]   dx, dy, ndx, ndy;
  logic [COORD_BITS-1:0] ax, ay;
  logic                  x_major;
  ddalr_pkg::oct_t       zone;

  // Divider and emit signals.
  logic [COORD_BITS:0]   rem2;
  logic                  q_bit;
  logic [AW-1:0]         rnd_sum;
  logic [COORD_BITS-1:0] rnd;
  logic                  slot_free;
  logic                  emit_fire;
  logic [AW-1:0]         slope_ext;

  // Deltas, magnitudes and octant of the latched line.
  always_comb begin
    dx      = {ex[COORD_BITS-1], ex} - {sx[COORD_BITS-1], sx};
    dy      = {ey[COORD_BITS-1], ey} - {sy[COORD_BITS-1], sy};
    ndx     = -dx;
    ndy     = -dy;
    ax      = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    ay      = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    x_major = ax > ay;
    case ({dx[COORD_BITS], dy[COORD_BITS]})
      2'b00:   zone = x_major ? ddalr_pkg::OCT_E_SHALLOW : ddalr_pkg::OCT_E_STEEP;
      2'b10:   zone = x_major ? ddalr_pkg::OCT_W_SHALLOW : ddalr_pkg::OCT_W_STEEP;
      2'b11:   zone = x_major ? ddalr_pkg::OCT_SW_SHALL  : ddalr_pkg::OCT_SW_STEEP;
      default: zone = x_major ? ddalr_pkg::OCT_SE_SHALL  : ddalr_pkg::OCT_SE_STEEP;
    endcase
  end

  // Restoring divider step: one quotient bit of minor / major.
  always_comb begin
    rem2  = {rem, 1'b0};
    q_bit = rem2 >= {1'b0, major};
  end

  // Round half up of the accumulator and the output slot handshake.
  always_comb begin
    rnd_sum   = acc + HALF;
    rnd       = rnd_sum[AW-1:FRAC_BITS];
    slot_free = !out_valid || out_ready;
    emit_fire = ctrl.emit && slot_free;
    slope_ext = {{COORD_BITS{1'b0}}, slope};
  end

  // Status for the jump logic.
  always_comb begin
    status.skip_div = (major == minor);
    status.div_busy = (divcnt != DIV_LAST);
    status.pix_done = slot_free && (count == '0);
  end

  // Endpoint capture on an input beat.
  always_ff @(posedge clk) begin
    if (ctrl.accept && in_valid) begin
      sx <= start_x;
      sy <= start_y;
      ex <= end_x;
      ey <= end_y;
    end
  end

  // Set-up, division and walk registers.
  always_ff @(posedge clk) begin
    if (ctrl.classify) begin
      steep     <= !x_major;
      line_oct  <= zone;
      maj_neg   <= x_major ? dx[COORD_BITS] : dy[COORD_BITS];
      min_neg   <= x_major ? dy[COORD_BITS] : dx[COORD_BITS];
      major     <= x_major ? ax : ay;
      minor     <= x_major ? ay : ax;
      maj_start <= x_major ? sx : sy;
      min_start <= x_major ? sy : sx;
    end
    if (ctrl.prep) begin
      acc    <= {min_start, {FRAC_BITS{1'b0}}};
      majpos <= maj_start;
      count  <= major;
      rem    <= minor;
      divcnt <= '0;
      // Equal nonzero travels saturate the slope just below one.
      slope  <= (major == minor && major != '0) ? {FRAC_BITS{1'b1}} : '0;
    end
    if (ctrl.div_step) begin
      rem    <= q_bit ? COORD_BITS'(rem2 - {1'b0, major}) : rem2[COORD_BITS-1:0];
      slope  <= {slope[FRAC_BITS-2:0], q_bit};
      divcnt <= divcnt + DCW'(1);
    end
    if (emit_fire) begin
      pixel_x    <= steep ? rnd : majpos;
      pixel_y    <= steep ? majpos : rnd;
      octant     <= line_oct;
      last_pixel <= (count == '0);
      majpos     <= maj_neg ? majpos - COORD_BITS'(1) : majpos + COORD_BITS'(1);
      acc        <= min_neg ? acc - slope_ext : acc + slope_ext;
      count      <= count - COORD_BITS'(1);
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ddalr_seq.sv =====
// ----------------------------------------------------------------------------
// ddalr_seq
// Microprogram sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
`default_nettype none

module ddalr_seq (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  input  wire ddalr_pkg::status_t status,
  output ddalr_pkg::ucode_t      ctrl
);

  ddalr_pkg::step_t step;
  ddalr_pkg::step_t step_next;
  logic             take;

  // Control word of the current step and the jump decision.
  always_comb begin
    ctrl = ddalr_pkg::ucode_rom(step);
    case (ctrl.cond)
      ddalr_pkg::COND_NEVER:    take = 1'b0;
      ddalr_pkg::COND_ALWAYS:   take = 1'b1;
      ddalr_pkg::COND_NO_INPUT: take = !in_valid;
      ddalr_pkg::COND_SKIP_DIV: take = status.skip_div;
      ddalr_pkg::COND_DIV_BUSY: take = status.div_busy;
      ddalr_pkg::COND_PIX_LEFT: take = !status.pix_done;
      default:                  take = 1'b1;
    endcase
    step_next = take ? ctrl.target : step + ddalr_pkg::STEP_BITS'(1);
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ddalr_pkg::STEP_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dda_line_rasterizer_top.sv =====
// Operation: after a line beat the slope divider runs one quotient bit per cycle, and is
//   skipped when both travels are equal; pixels then follow one per cycle while the
//   output accepts them. The input stays closed until the last pixel of a line is loaded.
// Reset: synchronous active-high rst returns the sequencer to its fetch step and
//   empties the output register.
// ----------------------------------------------------------------------------
// dda_line_rasterizer_top
// Eight-octant DDA line rasterizer driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_line_rasterizer_top #(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16
) (
  input  wire           clk,
  input  wire           rst,
  ddalr_line_if.sink    lines,
  ddalr_pixel_if.source pixels
);

  ddalr_pkg::ucode_t  ctrl;
  ddalr_pkg::status_t status;

  // Input channel is open only on the fetch step.
  assign lines.ready = ctrl.accept;

  ddalr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (lines.valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  ddalr_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .status     (status),
    .in_valid   (lines.valid),
    .start_x    (lines.start_x),
    .start_y    (lines.start_y),
    .end_x      (lines.end_x),
    .end_y      (lines.end_y),
    .out_valid  (pixels.valid),
    .out_ready  (pixels.ready),
    .pixel_x    (pixels.pixel_x),
    .pixel_y    (pixels.pixel_y),
    .octant     (pixels.octant),
    .last_pixel (pixels.last_pixel)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ddalr_chk.sv =====
// ----------------------------------------------------------------------------
// ddalr_chk
// Port-level checks of the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ddalr_chk (
  input wire                           clk,
  input wire                           rst,
  input wire                           in_valid,
  input wire                           in_ready,
  input wire                           out_valid,
  input wire                           out_ready,
  input wire                           out_last,
  input wire [ddalr_pkg::OCT_BITS-1:0] octant
);

  // A pending pixel beat is held until taken.
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "pixel beat dropped")

  // Only one line is in flight: the input closes right after a line beat.
  `ASSERT_NEXT(a_one_line, in_valid && in_ready, !in_ready, "second line accepted")

  // A new line is taken only once its predecessor has reached its last pixel.
  `ASSERT_IMPL(a_open_last, in_ready && out_valid, out_last, "line taken mid-line")

  // The octant does not change between pixels of the same line.
  `ASSERT_NEXT(a_oct_stable, out_valid && out_ready && !out_last, $stable(octant),
    "octant changed within a line")

endmodule

bind dda_line_rasterizer_top ddalr_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (lines.valid),
  .in_ready  (lines.ready),
  .out_valid (pixels.valid),
  .out_ready (pixels.ready),
  .out_last  (pixels.last_pixel),
  .octant    (pixels.octant)
);

`default_nettype wire
